// ----- hw/rtl/ape_pkg.sv -----
// Shared types, constants and sample decode functions for the audio peak envelope unit.
package ape_pkg;

	localparam int MAX_BUCKETS = 2048;

	localparam int CFG_W = 32;
	localparam int IDX_W = 3;

	localparam int DIV_N_W   = 44;
	localparam int DIV_D_W   = 32;
	localparam int DIV_CNT_W = 6;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic        FMT_PCM   = 1'b0;
	localparam logic        FMT_FLOAT = 1'b1;

	localparam logic [6:0] BITS_8  = 7'd8;
	localparam logic [6:0] BITS_16 = 7'd16;
	localparam logic [6:0] BITS_24 = 7'd24;
	localparam logic [6:0] BITS_32 = 7'd32;
	localparam logic [6:0] BITS_64 = 7'd64;

	localparam logic        RST_FORMAT  = FMT_PCM;
	localparam logic [6:0]  RST_BITS    = 7'd16;
	localparam logic [15:0] RST_CHANS   = 16'd2;
	localparam logic [15:0] RST_FBYTES  = 16'd4;
	localparam int          RST_TOTAL_I = 1;
	localparam int          RST_BUCK_I  = 2000;
	localparam logic [31:0] RST_TOTAL   = 32'(RST_TOTAL_I);
	localparam logic [11:0] RST_BUCKETS = 12'(RST_BUCK_I);
	localparam logic [11:0] RST_Q0      = 12'(RST_BUCK_I / RST_TOTAL_I);
	localparam logic [31:0] RST_R0      = 32'(RST_BUCK_I % RST_TOTAL_I);

	localparam logic signed [11:0] F32_EXP_OFS  = 12'sd119;
	localparam logic signed [11:0] F32_DEN_EXP  = -12'sd118;
	localparam logic signed [11:0] F64_EXP_OFS  = 12'sd1044;
	localparam logic signed [11:0] F64_DEN_EXP  = -12'sd1043;

	typedef enum logic [IDX_W-1:0] {
		REG_FORMAT  = 3'd0,
		REG_BITS    = 3'd1,
		REG_CHANS   = 3'd2,
		REG_FBYTES  = 3'd3,
		REG_TOTAL   = 3'd4,
		REG_BUCKETS = 3'd5
	} ape_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} ape_in_t;

	typedef struct packed {
		logic [10:0] bucket_index;
		logic [31:0] bucket_peak;
		logic        bucket_final;
		logic        clip_done;
	} ape_out_t;

	typedef struct packed {
		logic        sample_format;
		logic [6:0]  bits_per_sample;
		logic [15:0] channel_count;
		logic [15:0] frame_bytes;
		logic [31:0] frame_total;
		logic [11:0] bucket_count;
	} ape_cfg_t;

	// One queue entry per accepted byte.
	typedef struct packed {
		logic        clear;
		logic        smp_valid;
		logic [63:0] smp_bits;
		logic        frame_end;
		logic        first;
		logic        done;
	} ape_entry_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] mag;
	} ape_mag_t;

	function automatic logic [11:0] eff_buckets(input logic [11:0] bc);
		logic [11:0] r;
		if (bc == 12'd0) begin
			r = 12'd1;
		end else if (bc > 12'(MAX_BUCKETS)) begin
			r = 12'(MAX_BUCKETS);
		end else begin
			r = bc;
		end
		return r;
	endfunction

	// Magnitude sig * 2^e, truncated toward zero and saturated to 32 bits.
	function automatic logic [31:0] scale_mag(input logic [52:0] sig,
		input logic signed [11:0] e);
		logic [84:0] wide;
		logic [52:0] v;
		logic [11:0] n;
		logic [31:0] res;
		wide = '0;
		v    = '0;
		n    = '0;
		res  = '0;
		if (sig == '0) begin
			res = '0;
		end else if (!e[11]) begin
			if (e >= 12'sd32) begin
				res = '1;
			end else begin
				wide = {32'b0, sig} << e[4:0];
				res  = (wide[84:32] != '0) ? '1 : wide[31:0];
			end
		end else begin
			n = 12'(-e);
			if (n >= 12'd64) begin
				res = '0;
			end else begin
				v   = sig >> n[5:0];
				res = (v[52:32] != '0) ? '1 : v[31:0];
			end
		end
		return res;
	endfunction

	function automatic ape_mag_t decode_mag(input logic [63:0] raw, input logic fmt,
		input logic [6:0] bits);
		logic [7:0]  ex8;
		logic [10:0] ex11;
		logic [7:0]  b8;
		logic [15:0] v16;
		logic [23:0] v24;
		logic [31:0] v32;
		ape_mag_t    r;
		ex8   = raw[30:23];
		ex11  = raw[62:52];
		b8    = raw[7:0];
		v16   = raw[15] ? 16'(-raw[15:0]) : raw[15:0];
		v24   = raw[23] ? 24'(-raw[23:0]) : raw[23:0];
		v32   = raw[31] ? 32'(-raw[31:0]) : raw[31:0];
		r.ok  = 1'b1;
		r.mag = '0;
		if (fmt == FMT_FLOAT) begin
			if (bits == BITS_32) begin
				if (ex8 == 8'hFF) begin
					if (raw[22:0] != '0) r.ok = 1'b0;
					else r.mag = '1;
				end else if (ex8 == 8'd0) begin
					r.mag = scale_mag({30'b0, raw[22:0]}, F32_DEN_EXP);
				end else begin
					r.mag = scale_mag({29'b0, 1'b1, raw[22:0]},
						$signed({4'b0, ex8}) - F32_EXP_OFS);
				end
			end else if (bits == BITS_64) begin
				if (ex11 == 11'h7FF) begin
					if (raw[51:0] != '0) r.ok = 1'b0;
					else r.mag = '1;
				end else if (ex11 == 11'd0) begin
					r.mag = scale_mag({1'b0, raw[51:0]}, F64_DEN_EXP);
				end else begin
					r.mag = scale_mag({1'b1, raw[51:0]},
						$signed({1'b0, ex11}) - F64_EXP_OFS);
				end
			end
		end else begin
			unique case (bits)
				BITS_8: begin
					r.mag = {(b8[7] ? b8 - 8'd128 : 8'd128 - b8), 24'b0};
				end
				BITS_16: r.mag = {v16, 16'b0};
				BITS_24: r.mag = {v24, 8'b0};
				BITS_32: r.mag = v32;
				default: r.mag = '0;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/ape_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module ape_div import ape_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               done,
	output logic [DIV_N_W-1:0] quotient,
	output logic [DIV_D_W-1:0] remainder
);

	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_D_W:0]     trial;
	logic                 fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_N_W-1]};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
			rem_q <= fits ? DIV_D_W'(trial - {1'b0, divisor}) : trial[DIV_D_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- hw/rtl/ape_fifo.sv -----
// Short queue of classified byte entries between the front and back parts.
module ape_fifo import ape_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ape_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output ape_entry_t head
);

	ape_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign valid = cnt_q != '0;
	assign head  = mem_q[rd_q];

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != QCNT_W'(QDEPTH))
		else $error("push into full queue");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance on push");
`endif

endmodule

// ----- hw/rtl/ape_front.sv -----
// Front part: accepts data bytes, tracks frame position and assembles samples.
module ape_front import ape_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ape_cfg_t    cfg,
	input  logic        cfg_we,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  ape_in_t     byte_data,
	output logic        push,
	output ape_entry_t  push_entry,
	input  logic        q_full,
	output logic [31:0] frame_count
);

	typedef enum logic [1:0] {F_RUN, F_LOAD, F_WAIT} fstate_t;

	fstate_t     state_q;
	logic [15:0] bif_q;
	logic [3:0]  j_q;
	logic [15:0] s_q;
	logic [63:0] sb_q;
	logic [31:0] f_q;

	logic               div_done;
	logic [DIV_N_W-1:0] div_quo;
	logic [DIV_D_W-1:0] div_rem;

	logic        accept;
	logic [3:0]  bps;
	logic [15:0] fbytes;
	logic        clr;
	logic [15:0] bif;
	logic [3:0]  j;
	logic [15:0] s;
	logic [63:0] sb;
	logic [31:0] f;
	logic        ignore;
	logic [20:0] samp_end;
	logic        in_sample;
	logic [63:0] sb_new;
	logic        complete;
	logic        frame_end;

	ape_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == F_LOAD),
		.dividend ({28'b0, bif_q}),
		.divisor  ({28'b0, bps}),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_comb begin
		bps        = cfg.bits_per_sample[6:3];
		fbytes     = (cfg.frame_bytes == 16'd0) ? 16'd1 : cfg.frame_bytes;
		byte_ready = (state_q == F_RUN) && !q_full;
		accept     = byte_valid && byte_ready;
		clr        = byte_data.restart;
		bif        = clr ? '0 : bif_q;
		j          = clr ? '0 : j_q;
		s          = clr ? '0 : s_q;
		sb         = clr ? '0 : sb_q;
		f          = clr ? '0 : f_q;
		ignore     = f >= cfg.frame_total;
		samp_end   = 21'(s) * 21'(bps) + 21'(bps);
		in_sample  = (bps != 4'd0) && (s < cfg.channel_count) && (samp_end <= 21'(fbytes));
		sb_new     = sb;
		if (in_sample && !j[3]) sb_new[{j[2:0], 3'b000} +: 8] = byte_data.data_byte;
		complete   = in_sample && (j == bps - 4'd1);
		frame_end  = ({1'b0, bif} + 17'd1) >= {1'b0, fbytes};

		push                 = accept;
		push_entry.clear     = clr;
		push_entry.smp_valid = !ignore && complete;
		push_entry.smp_bits  = sb_new;
		push_entry.frame_end = !ignore && frame_end;
		push_entry.first     = f == '0;
		push_entry.done      = ({1'b0, f} + 33'd1) >= {1'b0, cfg.frame_total};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_RUN;
			bif_q   <= '0;
			j_q     <= '0;
			s_q     <= '0;
			sb_q    <= '0;
			f_q     <= '0;
		end else begin
			unique case (state_q)
				F_RUN: begin
					if (accept) begin
						bif_q <= bif;
						j_q   <= j;
						s_q   <= s;
						sb_q  <= sb;
						f_q   <= f;
						if (!ignore) begin
							if (frame_end) begin
								bif_q <= '0;
								j_q   <= '0;
								s_q   <= '0;
								sb_q  <= '0;
								f_q   <= f + 32'd1;
							end else begin
								bif_q <= bif + 16'd1;
								sb_q  <= complete ? '0 : sb_new;
								if (bps != 4'd0) begin
									if (j == bps - 4'd1) begin
										j_q <= '0;
										s_q <= s + 16'd1;
									end else begin
										j_q <= j + 4'd1;
									end
								end
							end
						end
					end
				end
				F_LOAD: state_q <= F_WAIT;
				F_WAIT: begin
					if (div_done) begin
						if (bps != 4'd0) begin
							s_q <= div_quo[15:0];
							j_q <= div_rem[3:0];
						end
						state_q <= F_RUN;
					end
				end
				default: state_q <= F_RUN;
			endcase
			// A new sample size moves the sample boundaries inside the frame.
			if (cfg_we) state_q <= F_LOAD;
		end
	end

	assign frame_count = f_q;

endmodule

// ----- hw/rtl/ape_back.sv -----
// Back part: decodes samples, keeps frame and bucket peaks and drives the result register.
module ape_back import ape_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ape_cfg_t    cfg,
	input  logic        cfg_we,
	input  logic [31:0] frame_count,
	input  logic        q_valid,
	input  ape_entry_t  q_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output ape_out_t    out_data
);

	typedef enum logic [2:0] {B_RUN, B_MUL, B_DIV1, B_WAIT1, B_DIV2, B_WAIT2} bstate_t;

	bstate_t     state_q;
	logic [43:0] prod_q;

	logic        v_s1;
	logic        clear_s1;
	logic        smp_s1;
	logic [31:0] mag_s1;
	logic        fe_s1;
	logic        first_s1;
	logic        done_s1;

	logic [31:0] fp_q;
	logic [11:0] b_q;
	logic [31:0] r_q;
	logic [11:0] q0_q;
	logic [31:0] r0_q;
	logic [31:0] run_q;
	logic [11:0] cur_q;
	logic        out_valid_q;
	ape_out_t    out_q;

	logic               div_start;
	logic [DIV_N_W-1:0] div_num;
	logic               div_done;
	logic [DIV_N_W-1:0] div_quo;
	logic [DIV_D_W-1:0] div_rem;

	logic [11:0] beff;
	logic [43:0] prod_c;
	logic        run;
	logic        adv2;
	logic        take;
	logic        fire2;
	ape_mag_t    dec;

	logic [31:0] fp;
	logic [31:0] fp2;
	logic [11:0] bb;
	logic [31:0] rr;
	logic [31:0] run_c;
	logic [11:0] cur;
	logic [32:0] rs;
	logic [11:0] bn;
	logic [31:0] newrun;
	logic        fin;

	ape_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (cfg.frame_total),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_comb begin
		beff      = eff_buckets(cfg.bucket_count);
		prod_c    = frame_count * beff;
		div_start = (state_q == B_DIV1) || (state_q == B_DIV2);
		div_num   = (state_q == B_DIV2) ? {32'b0, beff} : prod_q;
		run       = state_q == B_RUN;
		adv2      = !out_valid_q || out_ready;
		take      = run && (!v_s1 || adv2);
		fire2     = run && v_s1 && adv2;
		pop       = take && q_valid;
		dec       = decode_mag(q_entry.smp_bits, cfg.sample_format, cfg.bits_per_sample);

		fp    = clear_s1 ? '0 : fp_q;
		bb    = clear_s1 ? '0 : b_q;
		rr    = clear_s1 ? '0 : r_q;
		run_c = clear_s1 ? '0 : run_q;
		cur   = clear_s1 ? '0 : cur_q;
		fp2   = (smp_s1 && mag_s1 > fp) ? mag_s1 : fp;

		// Step floor(f*B/T) to the next frame with the precomputed B/T quotient.
		rs = {1'b0, rr} + {1'b0, r0_q};
		bn = bb + q0_q;
		if (rs >= {1'b0, cfg.frame_total}) begin
			rs = rs - {1'b0, cfg.frame_total};
			bn = bn + 12'd1;
		end
		newrun = (first_s1 || bb != cur) ? fp2 : ((fp2 > run_c) ? fp2 : run_c);
		fin    = done_s1 || (bn != bb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_RUN;
			v_s1        <= 1'b0;
			fp_q        <= '0;
			b_q         <= '0;
			r_q         <= '0;
			q0_q        <= RST_Q0;
			r0_q        <= RST_R0;
			run_q       <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_RUN: ;
				B_MUL: state_q <= B_DIV1;
				B_DIV1: state_q <= B_WAIT1;
				B_WAIT1: begin
					if (div_done) begin
						b_q     <= div_quo[11:0];
						r_q     <= div_rem;
						state_q <= B_DIV2;
					end
				end
				B_DIV2: state_q <= B_WAIT2;
				B_WAIT2: begin
					if (div_done) begin
						q0_q    <= div_quo[11:0];
						r0_q    <= div_rem;
						state_q <= B_RUN;
					end
				end
				default: state_q <= B_RUN;
			endcase
			if (cfg_we) state_q <= B_MUL;

			if (take) v_s1 <= q_valid;
			else if (fire2) v_s1 <= 1'b0;

			if (fire2) begin
				fp_q  <= fp2;
				b_q   <= bb;
				r_q   <= rr;
				run_q <= run_c;
				cur_q <= cur;
				if (fe_s1) begin
					fp_q  <= '0;
					b_q   <= bn;
					r_q   <= rs[31:0];
					run_q <= newrun;
					cur_q <= bb;
				end
			end

			if (fire2 && fe_s1) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_MUL) prod_q <= prod_c;
		if (take) begin
			clear_s1 <= q_entry.clear;
			smp_s1   <= q_entry.smp_valid && dec.ok;
			mag_s1   <= dec.mag;
			fe_s1    <= q_entry.frame_end;
			first_s1 <= q_entry.first;
			done_s1  <= q_entry.done;
		end
		if (fire2 && fe_s1) begin
			out_q.bucket_index <= bb[10:0];
			out_q.bucket_peak  <= newrun;
			out_q.bucket_final <= fin;
			out_q.clip_done    <= done_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/audio_peak_envelope_unit.sv -----
// Audio peak envelope unit: WAV byte stream to per-frame bucket peak results.
// Throughput is one data byte per cycle through the front, queue and back pipeline
// while no configuration reload runs and no result waits; a frame's last byte passes
// the queue and the back's sample register into the result register. After a
// configuration write the front reloads its sample position with a serial divider,
// the back runs two divisions, and up to four bytes wait in the queue till it resumes.
// Reset clears all counters and peaks and loads the default configuration.
module audio_peak_envelope_unit import ape_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_ready,
	input  ape_in_t          byte_data,
	output logic             env_valid,
	input  logic             env_ready,
	output ape_out_t         env_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	ape_cfg_t    cfg_q;
	logic        push;
	ape_entry_t  push_entry;
	logic        q_full;
	logic        pop;
	logic        q_valid;
	ape_entry_t  q_head;
	logic [31:0] frame_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format   <= RST_FORMAT;
			cfg_q.bits_per_sample <= RST_BITS;
			cfg_q.channel_count   <= RST_CHANS;
			cfg_q.frame_bytes     <= RST_FBYTES;
			cfg_q.frame_total     <= RST_TOTAL;
			cfg_q.bucket_count    <= RST_BUCKETS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT:  cfg_q.sample_format   <= cfg_wdata[0];
				REG_BITS:    cfg_q.bits_per_sample <= cfg_wdata[6:0];
				REG_CHANS:   cfg_q.channel_count   <= cfg_wdata[15:0];
				REG_FBYTES:  cfg_q.frame_bytes     <= cfg_wdata[15:0];
				REG_TOTAL:   cfg_q.frame_total     <= cfg_wdata[31:0];
				REG_BUCKETS: cfg_q.bucket_count    <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	ape_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cfg_we     (cfg_we),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full),
		.frame_count(frame_count)
	);

	ape_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	ape_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cfg_we     (cfg_we),
		.frame_count(frame_count),
		.q_valid    (q_valid),
		.q_entry    (q_head),
		.pop        (pop),
		.out_valid  (env_valid),
		.out_ready  (env_ready),
		.out_data   (env_data)
	);

endmodule

// ----- sim/audio_peak_envelope_unit_tb.sv -----
// Self-checking testbench for the audio peak envelope unit.
`timescale 1ns / 1ps

module audio_peak_envelope_unit_tb;
	import ape_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 12;

	// Tracks the envelope state of the clip and the results still owed by the unit.
	class envelope_scoreboard;
		logic        fmt;
		logic [6:0]  bits;
		logic [15:0] chans;
		logic [15:0] fbytes;
		logic [31:0] ftotal;
		logic [11:0] bcount;

		logic [15:0] byte_pos;
		logic [63:0] smp;
		logic [31:0] fpeak;
		logic [31:0] bpeak;
		logic [31:0] fcnt;
		logic [10:0] cur_bucket;

		ape_out_t    owed[$];
		int          errors;
		int          live_bytes;
		int          results;
		int          clip_ends;

		function new();
			fmt = RST_FORMAT;
			bits = RST_BITS;
			chans = RST_CHANS;
			fbytes = RST_FBYTES;
			ftotal = RST_TOTAL;
			bcount = RST_BUCKETS;
			errors = 0;
			live_bytes = 0;
			results = 0;
			clip_ends = 0;
			clear_clip();
		endfunction

		function void clear_clip();
			byte_pos = '0;
			smp = '0;
			fpeak = '0;
			bpeak = '0;
			fcnt = '0;
			cur_bucket = '0;
		endfunction

		function void set_reg(ape_reg_t r, logic [31:0] v);
			case (r)
				REG_FORMAT:  fmt = v[0];
				REG_BITS:    bits = v[6:0];
				REG_CHANS:   chans = v[15:0];
				REG_FBYTES:  fbytes = v[15:0];
				REG_TOTAL:   ftotal = v;
				REG_BUCKETS: bcount = v[11:0];
				default: ;
			endcase
		endfunction

		// sig * 2^e, truncated toward zero, saturated to 32 bits.
		function logic [31:0] shift_sat(logic [63:0] sig, int e);
			logic [127:0] wide;
			logic [63:0]  v;
			if (sig == 0) return '0;
			if (e >= 0) begin
				if (e >= 32) return '1;
				wide = {64'b0, sig} << e;
				return (wide[127:32] != 0) ? '1 : wide[31:0];
			end
			if (-e >= 64) return '0;
			v = sig >> (-e);
			return (v[63:32] != 0) ? '1 : v[31:0];
		endfunction

		// Returns 0 for NaN; otherwise m holds the Q1.31 magnitude.
		function bit sample_magnitude(logic [63:0] raw, output logic [31:0] m);
			logic [7:0]  ex8;
			logic [10:0] ex11;
			logic [7:0]  b;
			m = '0;
			if (fmt == FMT_FLOAT) begin
				if (bits == BITS_32) begin
					ex8 = raw[30:23];
					if (ex8 == 8'hFF) begin
						if (raw[22:0] != 0) return 0;
						m = '1;
					end else if (ex8 == 0) begin
						m = shift_sat({41'b0, raw[22:0]}, 1 - 150 + 31);
					end else begin
						m = shift_sat({40'b0, 1'b1, raw[22:0]}, int'(ex8) - 150 + 31);
					end
				end else if (bits == BITS_64) begin
					ex11 = raw[62:52];
					if (ex11 == 11'h7FF) begin
						if (raw[51:0] != 0) return 0;
						m = '1;
					end else if (ex11 == 0) begin
						m = shift_sat({12'b0, raw[51:0]}, 1 - 1075 + 31);
					end else begin
						m = shift_sat({11'b0, 1'b1, raw[51:0]}, int'(ex11) - 1075 + 31);
					end
				end
				return 1;
			end
			case (bits)
				BITS_8: begin
					b = raw[7:0];
					m = 32'(b[7] ? b - 8'd128 : 8'd128 - b) << 24;
				end
				BITS_16: m = (raw[15] ? 32'h10000 - 32'(raw[15:0]) : 32'(raw[15:0])) << 16;
				BITS_24: m = (raw[23] ? 32'h1000000 - 32'(raw[23:0]) : 32'(raw[23:0])) << 8;
				BITS_32: m = raw[31] ? 32'(-raw[31:0]) : raw[31:0];
				default: m = '0;
			endcase
			return 1;
		endfunction

		// Advances the envelope by one accepted byte and queues any frame result.
		function void note_byte(ape_in_t t);
			int unsigned      bps, fb, spf, s, j;
			longint unsigned  nb, f, nx, tot, b;
			logic [31:0]      m;
			bit               ok, done, fin;
			ape_out_t         r;
			bps = bits >> 3;
			fb = (fbytes == 0) ? 1 : fbytes;
			nb = (bcount == 0) ? 1 : bcount;
			if (nb > MAX_BUCKETS) nb = MAX_BUCKETS;
			spf = 0;
			if (t.restart) clear_clip();
			if (fcnt >= ftotal) return;
			live_bytes++;
			if (bps != 0) begin
				spf = fb / bps;
				if (chans < spf) spf = chans;
			end
			if (spf != 0) begin
				s = byte_pos / bps;
				j = byte_pos % bps;
				if (s < spf) begin
					if (j < 8) smp = smp | (64'(t.data_byte) << (8 * j));
					if (j == bps - 1) begin
						ok = sample_magnitude(smp, m);
						if (ok && m > fpeak) fpeak = m;
						smp = '0;
					end
				end
			end
			if (byte_pos + 1 < fb) begin
				byte_pos++;
				return;
			end
			f = fcnt;
			nx = f + 1;
			tot = ftotal;
			b = (f * nb) / tot;
			done = nx >= tot;
			fin = done || ((nx * nb) / tot != b);
			if (f == 0 || 11'(b) != cur_bucket) bpeak = fpeak;
			else if (fpeak > bpeak) bpeak = fpeak;
			cur_bucket = 11'(b);
			fcnt = 32'(nx);
			r.bucket_index = 11'(b);
			r.bucket_peak = bpeak;
			r.bucket_final = fin;
			r.clip_done = done;
			owed.push_back(r);
			fpeak = '0;
			byte_pos = '0;
			smp = '0;
		endfunction

		function void check_result(ape_out_t got);
			ape_out_t want;
			if (owed.size() == 0) begin
				$error("unexpected result: index %0d peak %h", got.bucket_index,
					got.bucket_peak);
				errors++;
				return;
			end
			want = owed.pop_front();
			results++;
			if (got.clip_done) clip_ends++;
			if (got.bucket_index !== want.bucket_index) begin
				$error("bucket_index: expected %0d, got %0d", want.bucket_index,
					got.bucket_index);
				errors++;
			end
			if (got.bucket_peak !== want.bucket_peak) begin
				$error("bucket_peak: expected %h, got %h", want.bucket_peak, got.bucket_peak);
				errors++;
			end
			if (got.bucket_final !== want.bucket_final) begin
				$error("bucket_final: expected %b, got %b", want.bucket_final,
					got.bucket_final);
				errors++;
			end
			if (got.clip_done !== want.clip_done) begin
				$error("clip_done: expected %b, got %b", want.clip_done, got.clip_done);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             byte_valid;
	logic             byte_ready;
	ape_in_t          byte_data;
	logic             env_valid;
	logic             env_ready;
	ape_out_t         env_data;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	envelope_scoreboard sb;
	int  cycles;
	int  burst_left;
	bit  hold_req;
	int  phases;

	audio_peak_envelope_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.env_valid  (env_valid),
		.env_ready  (env_ready),
		.env_data   (env_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && env_valid && env_ready) sb.check_result(env_data);
	end

	// Receiver stall pattern; a requested hold keeps ready low for a long stretch.
	initial begin
		int mode;
		int span;
		env_ready = 1'b0;
		mode = 0;
		span = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				env_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end
			if (span == 0) begin
				span = $urandom_range(8, 80);
				mode = $urandom_range(0, 3);
			end
			span--;
			case (mode)
				0: env_ready <= 1'b1;
				1: env_ready <= ($urandom_range(0, 9) < 7);
				2: env_ready <= ($urandom_range(0, 9) < 2);
				default: env_ready <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	// Offers one byte and waits for its transaction; bursts may end in random gaps.
	task automatic send_byte(logic [7:0] d, logic rs);
		ape_in_t t;
		int gap;
		t.data_byte = d;
		t.restart = rs;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		byte_data <= t;
		forever begin
			@(posedge clk);
			if (byte_ready) break;
		end
		sb.note_byte(t);
	endtask

	// Stops offering bytes and waits until every owed result has arrived.
	task automatic drain();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(logic f, logic [6:0] b, logic [15:0] ch, logic [15:0] fb,
		logic [31:0] tot, logic [11:0] bk);
		logic [31:0] vals[6];
		ape_reg_t r;
		drain();
		vals = '{32'(f), 32'(b), 32'(ch), 32'(fb), tot, 32'(bk)};
		for (int i = 0; i < 6; i++) begin
			r = ape_reg_t'(i);
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_wdata <= vals[i];
			sb.set_reg(r, vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] marks[8];
		marks = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h3F, 8'h4F, 8'h01, 8'hF0};
		if ($urandom_range(0, 3) == 0) return marks[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_list(logic [7:0] bs[$], logic first_restart);
		foreach (bs[i]) send_byte(bs[i], first_restart && i == 0);
	endtask

	initial begin
		logic        f;
		logic [6:0]  b;
		logic [15:0] ch;
		logic [15:0] fb;
		logic [31:0] tot;
		logic [11:0] bk;
		int          bps;
		int          nbytes;
		int          sel;
		bit          held;
		bit          paused;

		sb = new();
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FORMAT;
		cfg_wdata = '0;
		hold_req = 0;
		burst_left = 0;
		phases = 0;
		held = 0;
		paused = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 16-bit stereo: full negative, full positive, then a byte after the clip ended.
		configure(FMT_PCM, BITS_16, 16'd2, 16'd4, 32'd2, 12'd2);
		send_list('{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h12}, 1'b1);
		// 32-bit mono at the most negative code.
		configure(FMT_PCM, BITS_32, 16'd1, 16'd4, 32'd1, 12'd1);
		send_list('{8'h00, 8'h00, 8'h00, 8'h80}, 1'b1);
		// Float: infinity, then NaN with a zero bucket count.
		configure(FMT_FLOAT, BITS_32, 16'd1, 16'd4, 32'd2, 12'd0);
		send_list('{8'h00, 8'h00, 8'h80, 8'h7F, 8'h01, 8'h00, 8'h80, 8'hFF}, 1'b1);
		// Double 1.0 with an oversized bucket count.
		configure(FMT_FLOAT, BITS_64, 16'd1, 16'd8, 32'd1, 12'd4095);
		send_list('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'h3F}, 1'b1);

		while (sb.live_bytes < 610) begin
			sel = $urandom_range(0, 11);
			f = FMT_PCM;
			case (sel)
				0, 1: b = BITS_8;
				2, 3: b = BITS_16;
				4:    b = BITS_24;
				5:    b = BITS_32;
				6, 7: begin f = FMT_FLOAT; b = BITS_32; end
				8, 9: begin f = FMT_FLOAT; b = BITS_64; end
				default: begin
					f = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 3))
						0: b = 7'd0;
						1: b = 7'd4;
						2: b = 7'd40;
						default: b = 7'd127;
					endcase
				end
			endcase
			bps = b >> 3;
			ch = 16'($urandom_range(0, 3));
			if ($urandom_range(0, 19) == 0) ch = 16'hFFFF;
			fb = 16'((bps == 0 ? 1 : bps) * (ch == 0 ? 1 : (ch > 3 ? 3 : ch))
				+ $urandom_range(0, 2));
			if ($urandom_range(0, 9) == 0) fb = 16'($urandom_range(0, 2));
			tot = 32'($urandom_range(1, 12));
			if ($urandom_range(0, 24) == 0) tot = 32'd0;
			if ($urandom_range(0, 24) == 0) tot = 32'hFFFF_FFFF;
			case ($urandom_range(0, 6))
				0: bk = 12'd0;
				1: bk = 12'd1;
				2: bk = 12'd2048;
				3: bk = 12'd4095;
				4: bk = 12'($urandom_range(2, 5));
				default: bk = 12'($urandom_range(1, 4095));
			endcase
			// One phase with the widest frame: bytes go in but no frame ends.
			if (phases == 6) begin
				fb = 16'hFFFF;
				tot = 32'd3;
			end
			configure(f, b, ch, fb, tot, bk);
			if (!held && phases > 4) begin
				hold_req = 1;
				held = 1;
			end
			for (int clip = 0; clip < $urandom_range(1, 3); clip++) begin
				if (fb == 16'hFFFF) nbytes = 20;
				else if (tot == 0) nbytes = 5;
				else if (tot > 12) nbytes = 4 * (fb == 0 ? 1 : fb);
				else nbytes = tot * (fb == 0 ? 1 : fb) + $urandom_range(0, 2);
				for (int i = 0; i < nbytes && sb.live_bytes < 625; i++) begin
					send_byte(pick_byte(), i == 0 || $urandom_range(0, 59) == 0);
					if (!paused && held && i == nbytes / 2) begin
						drain();
						paused = 1;
					end
				end
			end
		end

		drain();
		if (sb.owed.size() != 0) begin
			$error("%0d results never arrived", sb.owed.size());
			sb.errors++;
		end
		$display("covered %0d setups, %0d live bytes, %0d frame results, %0d clip ends",
			phases, sb.live_bytes, sb.results, sb.clip_ends);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
